>>> design/brc_pkg.sv
package brc_pkg;

	localparam int SYMBOL_W       = 8;
	localparam int ROTOR_SEL_W    = 3;
	localparam int COUNT_W        = 24;
	localparam int CFG_W          = 3;
	localparam int MAX_ROTORS_DEF = 4;
	localparam int S_TDATA_W      = 24;
	localparam int M_TDATA_W      = 8;

	typedef enum logic [2:0] {
		CMD_ENCRYPT    = 3'd0,
		CMD_LOAD_WIRE  = 3'd1,
		CMD_LOAD_REFL  = 3'd2,
		CMD_LOAD_PLUG  = 3'd3,
		CMD_ROLL       = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIRE2,
		ST_PLUG_IN,
		ST_FWD,
		ST_REFL,
		ST_REV,
		ST_PLUG_OUT
	} state_t;

	typedef struct packed {
		logic                   step;
		logic                   roll;
		logic [ROTOR_SEL_W-1:0] idx;
		logic [SYMBOL_W-1:0]    amt;
		logic [ROTOR_SEL_W-1:0] n;
	} rotor_ctl_t;

endpackage

>>> design/byte_rotor_cipher_unit.sv
// Byte-wide rotor cipher. Table loads, rolls and encrypts arrive as items on the
// s_ stream; only an encrypt gives an item on the m_ stream. All wiring, reflector
// and plugboard tables sit in one single-port RAM, so an encrypt walks it one
// read per cycle; a wiring load writes the forward entry, then the reverse one.
// A finished byte waits in the output register while the next item is taken.
// The user writes rotors_in_use on the cfg_ channel only while idle; the block
// does not enforce it. Values above MAX_ROTORS act as MAX_ROTORS, zero bypasses
// the rotors. Tables must be loaded before they are used.
module byte_rotor_cipher_unit #(
	parameter int MAX_ROTORS = brc_pkg::MAX_ROTORS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [brc_pkg::CFG_W-1:0]     cfg_data,   // rotors_in_use
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// command[2:0], rotor_index[4:3], position[12:5], value[20:13], zero[23:21]
	input  logic [brc_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// cipher_byte[7:0]
	output logic [brc_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	localparam int DEPTH  = (2 * MAX_ROTORS + 2) * 256;
	localparam int AW     = $clog2(DEPTH);
	localparam int SW     = brc_pkg::SYMBOL_W;
	localparam int RSW    = brc_pkg::ROTOR_SEL_W;
	localparam logic [AW-1:0] REG_REV  = AW'(MAX_ROTORS);
	localparam logic [AW-1:0] REG_REFL = AW'(2 * MAX_ROTORS);
	localparam logic [AW-1:0] REG_PLUG = AW'(2 * MAX_ROTORS + 1);

	function automatic logic [AW-1:0] tab_addr(input logic [AW-1:0] region,
	                                           input logic [SW-1:0] idx);
		return (region << SW) | AW'(idx);
	endfunction

	brc_pkg::state_t   state_q, state_d;
	brc_pkg::cmd_t     cmd;
	brc_pkg::rotor_ctl_t rctl;

	logic [brc_pkg::CFG_W-1:0] rotors_q;
	logic [RSW-1:0] n;
	logic [1:0]     rot_in;
	logic [SW-1:0]  pos_in, val_in;
	logic           accept, rot_ok, out_free;

	logic [RSW-1:0] rot_q, rot_d, rd_idx;
	logic [SW-1:0]  s_q, s_d, s_cur, rd_pos, lookup;
	logic [SW-1:0]  pos_q, val_q;
	logic           last_q;

	logic           ram_en, ram_we;
	logic [AW-1:0]  ram_addr;
	logic [SW-1:0]  ram_wdata, ram_rdata;

	logic           m_valid_q, m_last_q;
	logic [SW-1:0]  m_data_q;

	assign cmd      = brc_pkg::cmd_t'(s_tdata[2:0]);
	assign rot_in   = s_tdata[4:3];
	assign pos_in   = s_tdata[12:5];
	assign val_in   = s_tdata[20:13];
	assign s_tready = (state_q == brc_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign rot_ok   = 32'(rot_in) < MAX_ROTORS;
	assign n        = (rotors_q > RSW'(MAX_ROTORS)) ? RSW'(MAX_ROTORS) : RSW'(rotors_q);
	assign out_free = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign lookup   = s_cur - rd_pos;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			brc_pkg::ST_IDLE: begin
				if (accept) begin
					case (cmd)
						brc_pkg::CMD_ENCRYPT:   state_d = brc_pkg::ST_PLUG_IN;
						brc_pkg::CMD_LOAD_WIRE: state_d = rot_ok ? brc_pkg::ST_WIRE2
						                                         : brc_pkg::ST_IDLE;
						default:                state_d = brc_pkg::ST_IDLE;
					endcase
				end
			end
			brc_pkg::ST_WIRE2:   state_d = brc_pkg::ST_IDLE;
			brc_pkg::ST_PLUG_IN: state_d = (n != '0) ? brc_pkg::ST_FWD : brc_pkg::ST_REFL;
			brc_pkg::ST_FWD: begin
				if (rot_q == n - RSW'(1)) state_d = brc_pkg::ST_REFL;
			end
			brc_pkg::ST_REFL:    state_d = (n != '0) ? brc_pkg::ST_REV : brc_pkg::ST_PLUG_OUT;
			brc_pkg::ST_REV: begin
				if (rot_q == '0) state_d = brc_pkg::ST_PLUG_OUT;
			end
			brc_pkg::ST_PLUG_OUT: begin
				if (out_free) state_d = brc_pkg::ST_IDLE;
			end
			default: state_d = brc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_idx = rot_q;
		s_cur  = s_q;
		unique case (state_q)
			brc_pkg::ST_PLUG_IN: begin
				s_cur  = ram_rdata;
				rd_idx = '0;
			end
			brc_pkg::ST_FWD: begin
				s_cur  = s_q + ram_rdata;
				rd_idx = rot_q + RSW'(1);
			end
			brc_pkg::ST_REFL: begin
				s_cur  = ram_rdata;
				rd_idx = n - RSW'(1);
			end
			brc_pkg::ST_REV: begin
				s_cur  = s_q + ram_rdata;
				rd_idx = rot_q - RSW'(1);
			end
			default: ;
		endcase
	end

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = '0;
		rot_d     = rot_q;
		s_d       = s_q;
		rctl      = '0;
		rctl.n    = n;
		rctl.idx  = RSW'(rot_in);
		rctl.amt  = val_in;
		unique case (state_q)
			brc_pkg::ST_IDLE: begin
				if (accept) begin
					case (cmd)
						brc_pkg::CMD_ENCRYPT: begin
							ram_en   = 1'b1;
							ram_addr = tab_addr(REG_PLUG, val_in);
						end
						brc_pkg::CMD_LOAD_WIRE: begin
							ram_en    = rot_ok;
							ram_we    = 1'b1;
							ram_addr  = tab_addr(AW'(rot_in), pos_in);
							ram_wdata = val_in - pos_in;
							rot_d     = RSW'(rot_in);
						end
						brc_pkg::CMD_LOAD_REFL: begin
							ram_en    = 1'b1;
							ram_we    = 1'b1;
							ram_addr  = tab_addr(REG_REFL, pos_in);
							ram_wdata = val_in;
						end
						brc_pkg::CMD_LOAD_PLUG: begin
							ram_en    = 1'b1;
							ram_we    = 1'b1;
							ram_addr  = tab_addr(REG_PLUG, pos_in);
							ram_wdata = val_in;
						end
						brc_pkg::CMD_ROLL: rctl.roll = rot_ok;
						default: ;
					endcase
				end
			end
			brc_pkg::ST_WIRE2: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = tab_addr(REG_REV + AW'(rot_q), val_q);
				ram_wdata = pos_q - val_q;
			end
			brc_pkg::ST_PLUG_IN: begin
				s_d    = s_cur;
				ram_en = 1'b1;
				if (n != '0) begin
					rot_d    = '0;
					ram_addr = tab_addr(AW'(rd_idx), lookup);
				end else begin
					ram_addr = tab_addr(REG_REFL, s_cur);
				end
			end
			brc_pkg::ST_FWD: begin
				s_d    = s_cur;
				ram_en = 1'b1;
				if (rot_q == n - RSW'(1)) begin
					ram_addr = tab_addr(REG_REFL, s_cur);
				end else begin
					rot_d    = rd_idx;
					ram_addr = tab_addr(AW'(rd_idx), lookup);
				end
			end
			brc_pkg::ST_REFL: begin
				s_d    = s_cur;
				ram_en = 1'b1;
				if (n != '0) begin
					rot_d    = rd_idx;
					ram_addr = tab_addr(REG_REV + AW'(rd_idx), lookup);
				end else begin
					ram_addr = tab_addr(REG_PLUG, s_cur);
				end
			end
			brc_pkg::ST_REV: begin
				s_d    = s_cur;
				ram_en = 1'b1;
				if (rot_q == '0) begin
					ram_addr = tab_addr(REG_PLUG, s_cur);
				end else begin
					rot_d    = rd_idx;
					ram_addr = tab_addr(REG_REV + AW'(rd_idx), lookup);
				end
			end
			brc_pkg::ST_PLUG_OUT: rctl.step = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= brc_pkg::ST_IDLE;
			rotors_q  <= brc_pkg::CFG_W'(1);
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				rotors_q <= cfg_data;
			end
			if (state_q == brc_pkg::ST_PLUG_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rot_q <= rot_d;
		s_q   <= s_d;
		if (accept) begin
			pos_q  <= pos_in;
			val_q  <= val_in;
			last_q <= s_tlast;
		end
		if (state_q == brc_pkg::ST_PLUG_OUT && out_free) begin
			m_data_q <= ram_rdata;
			m_last_q <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	brc_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	brc_rotors #(
		.MAX_ROTORS(MAX_ROTORS)
	) u_rotors (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (rctl),
		.rd_idx(rd_idx),
		.rd_pos(rd_pos)
	);

endmodule

>>> design/brc_ram.sv
module brc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

>>> design/brc_rotors.sv
module brc_rotors #(
	parameter int MAX_ROTORS = brc_pkg::MAX_ROTORS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  brc_pkg::rotor_ctl_t                 ctl,
	input  logic [brc_pkg::ROTOR_SEL_W-1:0]     rd_idx,
	output logic [brc_pkg::SYMBOL_W-1:0]        rd_pos
);

	localparam int RW = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;

	logic [brc_pkg::SYMBOL_W-1:0] pos_q [MAX_ROTORS];
	logic [brc_pkg::COUNT_W-1:0]  cnt_q;
	logic [brc_pkg::COUNT_W-1:0]  cnt_nxt;
	logic [MAX_ROTORS-1:0]        adv;

	always_comb begin
		logic [brc_pkg::COUNT_W-1:0] mask;
		cnt_nxt = cnt_q + brc_pkg::COUNT_W'(1);
		for (int i = 0; i < MAX_ROTORS; i++) begin
			if (i >= 3) begin
				mask = '1;
			end else begin
				mask = (brc_pkg::COUNT_W'(1) << (8 * i)) - brc_pkg::COUNT_W'(1);
			end
			adv[i] = (brc_pkg::ROTOR_SEL_W'(i) < ctl.n) && ((cnt_nxt & mask) == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < MAX_ROTORS; i++) begin
				pos_q[i] <= '0;
			end
		end else begin
			if (ctl.step) begin
				cnt_q <= cnt_nxt;
			end
			for (int i = 0; i < MAX_ROTORS; i++) begin
				if (ctl.step && adv[i]) begin
					pos_q[i] <= pos_q[i] + brc_pkg::SYMBOL_W'(1);
				end else if (ctl.roll && ctl.idx == brc_pkg::ROTOR_SEL_W'(i)) begin
					pos_q[i] <= pos_q[i] + ctl.amt;
				end
			end
		end
	end

	assign rd_pos = pos_q[rd_idx[RW-1:0]];

endmodule

>>> bench/byte_rotor_cipher_checker.sv
`timescale 1ns / 100ps

module byte_rotor_cipher_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [brc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [brc_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [brc_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          m_tlast,
	output int                            mismatches,
	output int                            pending,
	output int                            bytes_checked
);

	import brc_pkg::*;

	localparam int ROTORS = MAX_ROTORS_DEF;

	typedef struct packed {
		logic [SYMBOL_W-1:0] cipher;
		logic                eom;
	} cipher_item_t;

	logic [SYMBOL_W-1:0] fwd_off [0:ROTORS-1][0:255];
	logic [SYMBOL_W-1:0] rev_off [0:ROTORS-1][0:255];
	logic [SYMBOL_W-1:0] refl_map [0:255];
	logic [SYMBOL_W-1:0] plug_map [0:255];
	logic [SYMBOL_W-1:0] rotor_pos [0:ROTORS-1];
	logic [COUNT_W-1:0]  byte_count = '0;
	logic [CFG_W-1:0]    rotor_count = 3'd1;
	cipher_item_t        awaited [$];

	int mismatch_count = 0;
	int awaited_count = 0;
	int checked_count = 0;

	assign mismatches    = mismatch_count;
	assign pending       = awaited_count;
	assign bytes_checked = checked_count;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Full path for one byte, then odometer stepping of the active rotors.
	function automatic logic [SYMBOL_W-1:0] encipher_byte(input logic [SYMBOL_W-1:0] plain);
		int                  n;
		int                  i;
		logic [SYMBOL_W-1:0] s;
		logic [SYMBOL_W-1:0] idx;
		logic [COUNT_W-1:0]  mask;
		n = (rotor_count > ROTORS) ? ROTORS : int'(rotor_count);
		s = plug_map[plain];
		for (i = 0; i < n; i++) begin
			idx = s - rotor_pos[i];
			s = s + fwd_off[i][idx];
		end
		s = refl_map[s];
		for (i = n - 1; i >= 0; i--) begin
			idx = s - rotor_pos[i];
			s = s + rev_off[i][idx];
		end
		s = plug_map[s];
		byte_count = byte_count + 1'b1;
		for (i = 0; i < n; i++) begin
			mask = {COUNT_W{1'b1}} >> (COUNT_W - 8 * i);
			if ((byte_count & mask) == '0)
				rotor_pos[i] = rotor_pos[i] + 1'b1;
		end
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [2:0]          cmd;
		logic [1:0]          rot;
		logic [SYMBOL_W-1:0] pos;
		logic [SYMBOL_W-1:0] val;
		cipher_item_t        item;
		cipher_item_t        want;
		if (!arst_n) begin
			for (int r = 0; r < ROTORS; r++)
				rotor_pos[r] = '0;
			byte_count = '0;
			rotor_count = 3'd1;
			awaited.delete();
			awaited_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				rotor_count = cfg_data;
			if (s_tvalid && s_tready) begin
				cmd = s_tdata[2:0];
				rot = s_tdata[4:3];
				pos = s_tdata[12:5];
				val = s_tdata[20:13];
				case (cmd)
					CMD_ENCRYPT: begin
						item.cipher = encipher_byte(val);
						item.eom = s_tlast;
						awaited.push_back(item);
					end
					CMD_LOAD_WIRE: begin
						if (rot < ROTORS) begin
							fwd_off[rot][pos] = val - pos;
							rev_off[rot][val] = pos - val;
						end
					end
					CMD_LOAD_REFL: refl_map[pos] = val;
					CMD_LOAD_PLUG: plug_map[pos] = val;
					CMD_ROLL: begin
						if (rot < ROTORS)
							rotor_pos[rot] = rotor_pos[rot] + val;
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					report_mismatch($sformatf("cipher byte %02h arrived with none awaited",
						m_tdata));
				end else begin
					want = awaited.pop_front();
					checked_count++;
					if (m_tdata !== want.cipher)
						report_mismatch($sformatf("cipher byte %02h, predicted %02h",
							m_tdata, want.cipher));
					if (m_tlast !== want.eom)
						report_mismatch($sformatf("end of message %b, predicted %b",
							m_tlast, want.eom));
				end
			end
			awaited_count = awaited.size();
		end
	end

endmodule

>>> bench/byte_rotor_cipher_unit_test.sv
`timescale 1ns / 100ps

module byte_rotor_cipher_unit_test;

	import brc_pkg::*;

	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
	localparam int SETTLE_CYCLES = 24;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 125;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;  // command, rotor_index, position, value, zero
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;       // cipher_byte
	logic                   m_tlast;

	int mismatches;
	int pending;
	int bytes_checked;

	logic [7:0] perm [0:255];
	logic [2:0] phase_rotors [0:PHASES-1] = '{3'd2, 3'd4, 3'd1, 3'd0, 3'd6,
		3'd3, 3'd4, 3'd7, 3'd5, 3'd4};

	bit calm = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int n_encrypts = 0;
	int n_loads = 0;
	int n_rolls = 0;
	int n_spare = 0;
	int n_cfg = 0;

	always #4 clk = ~clk;

	byte_rotor_cipher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	byte_rotor_cipher_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.mismatches   (mismatches),
		.pending      (pending),
		.bytes_checked(bytes_checked)
	);

	// receiver stalls at random in short bursts, unless calm
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= (stall_left == 1);
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles without a handshake", quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic push_item(input logic [2:0] cmd, input logic [1:0] rot,
		input logic [7:0] pos, input logic [7:0] val, input logic last);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, val, pos, rot, cmd};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (cmd)
			CMD_ENCRYPT: n_encrypts++;
			CMD_LOAD_WIRE, CMD_LOAD_REFL, CMD_LOAD_PLUG: n_loads++;
			CMD_ROLL: n_rolls++;
			default: n_spare++;
		endcase
	endtask

	task automatic encrypt(input logic [7:0] plain, input logic last);
		push_item(CMD_ENCRYPT, 2'($urandom), 8'($urandom), plain, last);
	endtask

	task automatic shuffle_perm();
		int j;
		logic [7:0] t;
		for (int i = 0; i < 256; i++)
			perm[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
	endtask

	task automatic load_rotor(input logic [1:0] rot);
		shuffle_perm();
		for (int p = 0; p < 256; p++)
			push_item(CMD_LOAD_WIRE, rot, 8'(p), perm[p], 1'($urandom));
	endtask

	// stop sending, let every awaited byte arrive, then give the block time to go idle
	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_rotor_count(input logic [2:0] n);
		drain_and_settle();
		cfg_valid <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	// mostly encrypts; the rest rolls, table rewrites and unused commands
	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 66)
			encrypt(8'($urandom), $urandom_range(0, 7) == 0);
		else if (r < 76)
			push_item(CMD_ROLL, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
		else if (r < 86)
			push_item(CMD_LOAD_WIRE, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
		else if (r < 91)
			push_item(CMD_LOAD_REFL, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
		else if (r < 96)
			push_item(CMD_LOAD_PLUG, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
		else
			push_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 2'($urandom),
				8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		shuffle_perm();
		for (int p = 0; p < 256; p++)
			push_item(CMD_LOAD_PLUG, 2'($urandom), 8'(p), perm[p], 1'($urandom));
		for (int p = 0; p < 256; p++)
			push_item(CMD_LOAD_REFL, 2'($urandom), 8'(p), 8'($urandom), 1'($urandom));
		load_rotor(2'd0);

		// one rotor active out of reset
		encrypt(8'h00, 1'b0);
		encrypt(8'hFF, 1'b1);
		encrypt(8'hA5, 1'b0);
		push_item(CMD_SPARE_LO, 2'd3, 8'hFF, 8'hFF, 1'b1);
		push_item(CMD_SPARE_MID, 2'd0, 8'h00, 8'h00, 1'b0);
		push_item(CMD_SPARE_HI, 2'd2, 8'h81, 8'h7E, 1'b1);
		push_item(CMD_ROLL, 2'd0, 8'h00, 8'hFF, 1'b0);
		encrypt(8'h3C, 1'b1);
		push_item(CMD_ROLL, 2'd0, 8'hFF, 8'h00, 1'b0);
		push_item(CMD_ROLL, 2'd3, 8'h00, 8'h01, 1'b0);
		// duplicate wiring value: rotor 0 stops being a permutation
		push_item(CMD_LOAD_WIRE, 2'd0, 8'h00, perm[1], 1'b0);
		encrypt(8'h00, 1'b0);
		push_item(CMD_LOAD_REFL, 2'd1, 8'hFF, 8'h00, 1'b1);
		push_item(CMD_LOAD_PLUG, 2'd2, 8'h00, 8'hFF, 1'b0);
		encrypt(8'hFF, 1'b0);
		encrypt(8'h00, 1'b1);

		for (int r = 1; r < 4; r++)
			load_rotor(2'(r));

		set_rotor_count(3'd4);
		encrypt(8'h80, 1'b1);
		encrypt(8'h7F, 1'b0);
		set_rotor_count(3'd0);
		encrypt(8'h01, 1'b0);
		encrypt(8'hFE, 1'b1);
		set_rotor_count(3'd7);
		encrypt(8'h55, 1'b1);
		push_item(CMD_ROLL, 2'd2, 8'h00, 8'h80, 1'b0);
		encrypt(8'hAA, 1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph >= PHASES - 2)
				calm = 1'b1;
			set_rotor_count(phase_rotors[ph]);
			repeat (PHASE_ITEMS) random_item();
		end

		drain_and_settle();
		$display("covered %0d encrypts, %0d table loads, %0d rolls, %0d unused commands",
			n_encrypts, n_loads, n_rolls, n_spare);
		$display("%0d rotor count writes from 0 to 7, %0d cipher bytes checked",
			n_cfg, bytes_checked);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
